@@ sv/wsg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waveform sample generator package
// Shared types, command word and fixed constants for the controller and the
// datapath of the waveform sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // Field widths fixed by the register map
  localparam int AMP_W  = 12;
  localparam int DUTY_W = 7;

  // Sequencer step counts
  localparam int HORNER_STEPS = 4;
  localparam int DIV_STEPS    = AMP_W;
  localparam int CNT_W        = 4;

  // Quarter-wave sine polynomial coefficients, Q2.30
  localparam logic signed [31:0] SIN_C1 = 32'sd1686629713;
  localparam logic signed [31:0] SIN_C3 = -32'sd693598673;
  localparam logic signed [31:0] SIN_C5 = 32'sd85569306;
  localparam logic signed [31:0] SIN_C7 = -32'sd5026995;
  localparam logic signed [31:0] SIN_C9 = 32'sd172272;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2
  } wave_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIN_SQ,
    ST_SIN_X2,
    ST_SIN_HMUL,
    ST_SIN_HADD,
    ST_SIN_MMUL,
    ST_SIN_MAG,
    ST_SIN_CMUL,
    ST_SIN_CODE,
    ST_FLAT,
    ST_TRI_MUL,
    ST_TRI_INIT,
    ST_TRI_DIV,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_XX,
    OP_X2,
    OP_MUL_PX2,
    OP_HORNER,
    OP_MUL_PX,
    OP_MAG,
    OP_MUL_OFF,
    OP_SINE_CODE,
    OP_FLAT,
    OP_MUL_TRI,
    OP_DIV_INIT,
    OP_DIV_STEP
  } dp_op_t;

  typedef struct packed {
    logic             load;
    logic             out_load;
    dp_op_t           op;
    logic [CNT_W-1:0] step;
  } dp_cmd_t;

  // Horner coefficient for each accumulate step, highest order first
  function automatic logic signed [31:0] horner_coef(input logic [1:0] idx);
    logic signed [31:0] c;
    case (idx)
      2'd0:    c = SIN_C7;
      2'd1:    c = SIN_C5;
      2'd2:    c = SIN_C3;
      default: c = SIN_C1;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/wsg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waveform sample generator controller
// Sequences one sample through the shared multiplier, the bit-serial divider
// or the flat step, and owns the output word valid flag.
// ----------------------------------------------------------------------------
module wsg_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  wsg_pkg::wave_kind_t wave_kind,
  output wsg_pkg::dp_cmd_t    cmd
);
  import wsg_pkg::*;

  ctl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (wave_kind)
            WAVE_SINE:     state_nxt = ST_SIN_SQ;
            WAVE_TRIANGLE: state_nxt = ST_TRI_MUL;
            default:       state_nxt = ST_FLAT;
          endcase
        end
      end
      ST_SIN_SQ:   state_nxt = ST_SIN_X2;
      ST_SIN_X2:   state_nxt = ST_SIN_HMUL;
      ST_SIN_HMUL: state_nxt = ST_SIN_HADD;
      ST_SIN_HADD: begin
        state_nxt = (cnt_r == CNT_W'(HORNER_STEPS - 1)) ? ST_SIN_MMUL : ST_SIN_HMUL;
      end
      ST_SIN_MMUL: state_nxt = ST_SIN_MAG;
      ST_SIN_MAG:  state_nxt = ST_SIN_CMUL;
      ST_SIN_CMUL: state_nxt = ST_SIN_CODE;
      ST_SIN_CODE: state_nxt = ST_FINISH;
      ST_FLAT:     state_nxt = ST_FINISH;
      ST_TRI_MUL:  state_nxt = ST_TRI_INIT;
      ST_TRI_INIT: state_nxt = ST_TRI_DIV;
      ST_TRI_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath command
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.step     = cnt_r;
    in_ready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SIN_SQ:   cmd.op = OP_MUL_XX;
      ST_SIN_X2:   cmd.op = OP_X2;
      ST_SIN_HMUL: cmd.op = OP_MUL_PX2;
      ST_SIN_HADD: cmd.op = OP_HORNER;
      ST_SIN_MMUL: cmd.op = OP_MUL_PX;
      ST_SIN_MAG:  cmd.op = OP_MAG;
      ST_SIN_CMUL: cmd.op = OP_MUL_OFF;
      ST_SIN_CODE: cmd.op = OP_SINE_CODE;
      ST_FLAT:     cmd.op = OP_FLAT;
      ST_TRI_MUL:  cmd.op = OP_MUL_TRI;
      ST_TRI_INIT: cmd.op = OP_DIV_INIT;
      ST_TRI_DIV:  cmd.op = OP_DIV_STEP;
      ST_FINISH:   cmd.out_load = out_free;
      default:     cmd.op = OP_NONE;
    endcase
  end

  // Step counter: cleared per word, advanced by the Horner and divide loops
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (state_r == ST_SIN_HADD || state_r == ST_TRI_DIV) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Output word valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Never overwrite a word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before it was taken");

  // An accepted word always starts a sequence
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r != ST_IDLE))
    else $error("accepted word did not leave idle");

  // Loop counters stay inside their loops
  a_horner_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIN_HADD) |-> (cnt_r < CNT_W'(HORNER_STEPS)))
    else $error("Horner step count out of range");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRI_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divide step count out of range");

  // A new output word only appears after the finish step
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("output valid raised outside finish");

endmodule
`default_nettype wire

@@ sv/wsg_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Waveform sample generator datapath
// Phase accumulator, shared 32x32 multiplier, quarter-wave sine polynomial,
// duty edge table, bit-serial divider and output word register.
// ----------------------------------------------------------------------------
module wsg_datapath #(
  parameter int TABLE_LENGTH = 256,
  parameter int CODE_BITS    = 12
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wsg_pkg::dp_cmd_t            cmd,
  input  wire                         in_restart,
  input  wsg_pkg::wave_kind_t         wave_kind,
  input  wire [wsg_pkg::AMP_W-1:0]    amplitude,
  input  wire [wsg_pkg::DUTY_W-1:0]   duty,
  output logic [CODE_BITS-1:0]        out_sample_code,
  output logic                        out_period_end
);
  import wsg_pkg::*;

  localparam int IW = $clog2(TABLE_LENGTH);
  localparam longint unsigned TURN = 64'd1 << 32;
  localparam longint unsigned PH_Q = TURN / TABLE_LENGTH;
  localparam longint unsigned PH_R = TURN % TABLE_LENGTH;
  localparam logic [IW:0] LEN = (IW + 1)'(TABLE_LENGTH);
  localparam int DUTY_CODES = 1 << DUTY_W;
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] DUTY_TRI_MAX = DUTY_W'(99);
  localparam logic [DUTY_W-1:0] DUTY_TRI_MIN = DUTY_W'(1);

  // Divide by 2^30, truncating toward zero
  function automatic logic signed [33:0] div_q30(input logic signed [63:0] v);
    logic signed [63:0] b;
    b = v + (v[63] ? 64'sd1073741823 : 64'sd0);
    return b[63:30];
  endfunction

  // Duty edge table: TABLE_LENGTH * duty / 100 for every duty code
  logic [IW:0] edge_tab [DUTY_CODES];
  for (genvar d = 0; d < DUTY_CODES; d++) begin : g_edge
    localparam longint unsigned EDGE = longint'(TABLE_LENGTH) * d / 100;
    assign edge_tab[d] = (IW + 1)'(EDGE);
  end

  // Phase state
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0]   t_r, t_nxt;
  logic [IW-1:0] fr_r, fr_nxt;

  // Per-word and working registers
  logic [IW-1:0]        cur_i_r, cur_i_nxt;
  logic [30:0]          x_r, x_nxt;
  logic [1:0]           quad_r, quad_nxt;
  logic                 last_r, last_nxt;
  logic signed [63:0]   prod_r, prod_nxt;
  logic [30:0]          x2_r, x2_nxt;
  logic signed [31:0]   p_r, p_nxt;
  logic [15:0]          off_r, off_nxt;
  logic [IW:0]          den_r, den_nxt;
  logic [IW:0]          drem_r, drem_nxt;
  logic [AMP_W-1:0]     dq_r, dq_nxt;
  logic [AMP_W-1:0]     result_r, result_nxt;
  logic [CODE_BITS-1:0] out_code_r, out_code_nxt;
  logic                 out_end_r, out_end_nxt;

  // Phase selection at load and its successor
  logic [IW-1:0] i_sel, fr_sel, fr_adv;
  logic [31:0]   t_sel, t_adv;
  logic [IW:0]   i_inc, fr_sum;
  logic          wrap, fr_carry;

  always_comb begin
    i_sel    = in_restart ? '0 : idx_r;
    t_sel    = in_restart ? '0 : t_r;
    fr_sel   = in_restart ? '0 : fr_r;
    i_inc    = {1'b0, i_sel} + 1'b1;
    wrap     = (i_inc == LEN);
    fr_sum   = {1'b0, fr_sel} + (IW + 1)'(PH_R);
    fr_carry = (fr_sum >= LEN);
    fr_adv   = fr_carry ? IW'(fr_sum - LEN) : fr_sum[IW-1:0];
    t_adv    = t_sel + 32'(PH_Q) + 32'(fr_carry);
  end

  // Duty edges
  logic [DUTY_W-1:0] duty_tri;
  logic [IW:0]       edge_sq, edge_tri, i_ext;
  logic              tri_rise;
  logic [IW:0]       tri_k;

  always_comb begin
    if (duty >= DUTY_FULL) begin
      duty_tri = DUTY_TRI_MAX;
    end else if (duty == '0) begin
      duty_tri = DUTY_TRI_MIN;
    end else begin
      duty_tri = duty;
    end
    edge_sq  = edge_tab[duty];
    edge_tri = edge_tab[duty_tri];
    i_ext    = {1'b0, cur_i_r};
    tri_rise = (i_ext < edge_tri);
    tri_k    = tri_rise ? i_ext : LEN - i_ext;
  end

  // Shared multiplier operands
  logic signed [31:0] mul_a, mul_b;
  logic               mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_XX: begin
        mul_a = $signed(32'(x_r));
        mul_b = $signed(32'(x_r));
      end
      OP_MUL_PX2: begin
        mul_a = p_r;
        mul_b = $signed(32'(x2_r));
      end
      OP_MUL_PX: begin
        mul_a = p_r;
        mul_b = $signed(32'(x_r));
      end
      OP_MUL_OFF: begin
        mul_a = $signed(32'(amplitude));
        mul_b = $signed(32'(off_r));
      end
      OP_MUL_TRI: begin
        mul_a = $signed(32'(amplitude));
        mul_b = $signed(32'(tri_k));
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Product scaling, sine magnitude and divide step
  logic signed [31:0] coef;
  logic signed [33:0] q30;
  logic signed [33:0] hsum;
  logic [33:0]        m_pos, m_rnd;
  logic [18:0]        mag_full;
  logic [14:0]        mag;
  logic [IW+1:0]      trial;
  logic               trial_ge;
  logic [IW+1:0]      trial_sub;

  always_comb begin
    coef      = horner_coef(cmd.step[1:0]);
    q30       = div_q30(prod_r);
    hsum      = {{2{coef[31]}}, coef} + q30;
    m_pos     = q30[33] ? '0 : q30;
    m_rnd     = m_pos + 34'd16384;
    mag_full  = m_rnd[33:15];
    mag       = (mag_full > 19'd32767) ? 15'h7fff : mag_full[14:0];
    trial     = {drem_r, dq_r[AMP_W-1]};
    trial_ge  = (trial >= {1'b0, den_r});
    trial_sub = trial - {1'b0, den_r};
  end

  // Register updates per command
  always_comb begin
    idx_nxt      = idx_r;
    t_nxt        = t_r;
    fr_nxt       = fr_r;
    cur_i_nxt    = cur_i_r;
    x_nxt        = x_r;
    quad_nxt     = quad_r;
    last_nxt     = last_r;
    prod_nxt     = mul_en ? mul_a * mul_b : prod_r;
    x2_nxt       = x2_r;
    p_nxt        = p_r;
    off_nxt      = off_r;
    den_nxt      = den_r;
    drem_nxt     = drem_r;
    dq_nxt       = dq_r;
    result_nxt   = result_r;
    out_code_nxt = out_code_r;
    out_end_nxt  = out_end_r;

    // Latch this word's phase, advance the accumulator
    if (cmd.load) begin
      cur_i_nxt = i_sel;
      quad_nxt  = t_sel[31:30];
      x_nxt     = t_sel[30] ? (31'h4000_0000 - {1'b0, t_sel[29:0]}) : {1'b0, t_sel[29:0]};
      last_nxt  = (i_inc == LEN);
      idx_nxt   = wrap ? '0 : i_inc[IW-1:0];
      t_nxt     = wrap ? '0 : t_adv;
      fr_nxt    = wrap ? '0 : fr_adv;
    end

    case (cmd.op)
      OP_X2: begin
        x2_nxt = q30[30:0];
        p_nxt  = SIN_C9;
      end
      OP_HORNER:    p_nxt = hsum[31:0];
      OP_MAG:       off_nxt = quad_r[1] ? 16'h8000 - 16'(mag) : 16'h8000 + 16'(mag);
      OP_SINE_CODE: result_nxt = prod_r[27:16];
      OP_FLAT: begin
        result_nxt = (wave_kind == WAVE_SQUARE && i_ext < edge_sq) ? amplitude : '0;
      end
      OP_MUL_TRI:   den_nxt = tri_rise ? edge_tri : LEN - edge_tri;
      OP_DIV_INIT: begin
        drem_nxt = {1'b0, prod_r[IW+AMP_W-1:AMP_W]};
        dq_nxt   = prod_r[AMP_W-1:0];
      end
      OP_DIV_STEP: begin
        drem_nxt   = trial_ge ? trial_sub[IW:0] : trial[IW:0];
        dq_nxt     = {dq_r[AMP_W-2:0], trial_ge};
        result_nxt = {dq_r[AMP_W-2:0], trial_ge};
      end
      default: p_nxt = p_r;
    endcase

    // Hand the finished word to the output register
    if (cmd.out_load) begin
      out_code_nxt = CODE_BITS'(result_r);
      out_end_nxt  = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      t_r   <= '0;
      fr_r  <= '0;
    end else begin
      idx_r <= idx_nxt;
      t_r   <= t_nxt;
      fr_r  <= fr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_i_r    <= cur_i_nxt;
    x_r        <= x_nxt;
    quad_r     <= quad_nxt;
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    x2_r       <= x2_nxt;
    p_r        <= p_nxt;
    off_r      <= off_nxt;
    den_r      <= den_nxt;
    drem_r     <= drem_nxt;
    dq_r       <= dq_nxt;
    result_r   <= result_nxt;
    out_code_r <= out_code_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_sample_code = out_code_r;
  assign out_period_end  = out_end_r;

endmodule
`default_nettype wire

@@ sv/waveform_sample_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sine words make seven passes through the shared 32x32 multiplier, triangle words
// run a 12-step bit-serial divider, and square and unknown kinds go through the
// flat step. A new word is accepted only in idle, once the previous one has been
// loaded into the output register.
// A finished word that is not yet taken holds the sequence in its last step.
// Reset: synchronous, phase zero, sine, amplitude 3722, duty 50; no clearing pass.
// ----------------------------------------------------------------------------
// Waveform sample generator
// One DAC channel: sine, square or triangle code per sample word, with a
// configuration write port for wave kind, amplitude and duty.
// ----------------------------------------------------------------------------
module waveform_sample_generator #(
  parameter int TABLE_LENGTH = 256,
  parameter int CODE_BITS    = 12
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_restart,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [CODE_BITS-1:0] out_sample_code,
  output logic                 out_period_end,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [1:0]            cfg_index,
  input  wire [11:0]           cfg_data
);
  import wsg_pkg::*;

  localparam logic [1:0] CFG_WAVE_KIND = 2'd0;
  localparam logic [1:0] CFG_AMPLITUDE = 2'd1;
  localparam logic [1:0] CFG_DUTY      = 2'd2;
  localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(3722);
  localparam logic [DUTY_W-1:0] DUTY_RESET = DUTY_W'(50);

  logic [1:0]        kind_r, kind_nxt;
  logic [AMP_W-1:0]  amp_r, amp_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  wave_kind_t        wave_kind;
  dp_cmd_t           cmd;

  // Configuration writes, masked to register width
  assign cfg_ready = 1'b1;

  always_comb begin
    kind_nxt = kind_r;
    amp_nxt  = amp_r;
    duty_nxt = duty_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WAVE_KIND: kind_nxt = cfg_data[1:0];
        CFG_AMPLITUDE: amp_nxt  = cfg_data[AMP_W-1:0];
        CFG_DUTY:      duty_nxt = cfg_data[DUTY_W-1:0];
        default:       kind_nxt = kind_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= WAVE_SINE;
      amp_r  <= AMP_RESET;
      duty_r <= DUTY_RESET;
    end else begin
      kind_r <= kind_nxt;
      amp_r  <= amp_nxt;
      duty_r <= duty_nxt;
    end
  end

  assign wave_kind = wave_kind_t'(kind_r);

  wsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .wave_kind (wave_kind),
    .cmd       (cmd)
  );

  wsg_datapath #(
    .TABLE_LENGTH (TABLE_LENGTH),
    .CODE_BITS    (CODE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_restart      (in_restart),
    .wave_kind       (wave_kind),
    .amplitude       (amp_r),
    .duty            (duty_r),
    .out_sample_code (out_sample_code),
    .out_period_end  (out_period_end)
  );

endmodule
`default_nettype wire

@@ sim/waveform_sample_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform sample generator testbench
// Drives sample words with random restarts through the valid/ready channel,
// retunes wave kind, amplitude and duty between runs of words, and checks
// every DAC code and period marker against a cycle-free model of the phase
// accumulator and the sine, square and triangle shapers.
// ----------------------------------------------------------------------------
module waveform_sample_generator_tb;
  import wsg_pkg::*;

  localparam int TABLE_LENGTH = 256;
  localparam int CODE_BITS    = 12;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;
  localparam longint Q30      = 64'sd1073741824;
  localparam logic [1:0] WAVE_UNKNOWN = 2'd3;

  typedef enum logic [1:0] {
    REG_WAVE_KIND = 2'd0,
    REG_AMPLITUDE = 2'd1,
    REG_DUTY      = 2'd2,
    REG_SPARE     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 period_end;
  } dac_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CODE_BITS-1:0] out_sample_code;
  logic out_period_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_WAVE_KIND;
  logic [11:0] cfg_data = 12'd0;

  // Shadow of the block's registers and phase
  logic [1:0] wave_sel = WAVE_SINE;
  logic [11:0] amp_level = 12'd3722;
  logic [6:0] duty_level = 7'd50;
  int unsigned next_phase = 0;

  logic pending_restarts[$];
  dac_word_t expected_words[$];
  bit idle_on = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_cycles = 0;
  int fail_cnt = 0;

  waveform_sample_generator #(
    .TABLE_LENGTH(TABLE_LENGTH),
    .CODE_BITS(CODE_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_code(out_sample_code),
    .out_period_end(out_period_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Quarter-wave Taylor sine in Q1.15, signed by quadrant
  function automatic int sine_q15(input int unsigned idx);
    longint unsigned turn;
    logic [1:0] quad;
    longint x;
    longint x2;
    longint acc;
    longint m;
    longint mag;
    turn = (longint'(idx) << 32) / longint'(TABLE_LENGTH);
    quad = turn[31:30];
    x = longint'(turn & 64'h3FFF_FFFF);
    if (quad[0]) begin
      x = Q30 - x;
    end
    x2 = (x * x) / Q30;
    acc = longint'(SIN_C9);
    acc = longint'(SIN_C7) + (acc * x2) / Q30;
    acc = longint'(SIN_C5) + (acc * x2) / Q30;
    acc = longint'(SIN_C3) + (acc * x2) / Q30;
    acc = longint'(SIN_C1) + (acc * x2) / Q30;
    m = (acc * x) / Q30;
    if (m < 0) begin
      m = 0;
    end
    mag = (m + 16384) >>> 15;
    if (mag > 32767) begin
      mag = 32767;
    end
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  // DAC code for one phase index under the current shadow registers
  function automatic logic [CODE_BITS-1:0] dac_code_at(input int unsigned idx);
    int unsigned len;
    int unsigned amp;
    int unsigned duty;
    int unsigned edge_idx;
    int unsigned code;
    len = TABLE_LENGTH;
    amp = amp_level;
    duty = duty_level;
    code = 0;
    case (wave_sel)
      WAVE_SINE: begin
        code = (amp * int'(sine_q15(idx) + 32768)) >> 16;
      end
      WAVE_SQUARE: begin
        edge_idx = len * duty / 100;
        code = (idx < edge_idx) ? amp : 0;
      end
      WAVE_TRIANGLE: begin
        if (duty >= 100) begin
          duty = 99;
        end else if (duty == 0) begin
          duty = 1;
        end
        edge_idx = len * duty / 100;
        if (idx < edge_idx) begin
          code = amp * idx / edge_idx;
        end else begin
          code = amp * (len - idx) / (len - edge_idx);
        end
      end
      default: begin
        code = 0;
      end
    endcase
    return code[CODE_BITS-1:0];
  endfunction

  // Input driver: present queued words, predict each accepted one
  always @(posedge clk) begin : drive_words
    int unsigned idx;
    dac_word_t word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        idx = (in_restart || next_phase >= TABLE_LENGTH) ? 0 : next_phase;
        word.code = dac_code_at(idx);
        word.period_end = (idx == TABLE_LENGTH - 1);
        expected_words.push_back(word);
        next_phase = (idx + 1 >= TABLE_LENGTH) ? 0 : idx + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else if (pending_restarts.size() != 0) begin
          in_valid <= 1'b1;
          in_restart <= pending_restarts.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: stall in bursts, check each word against the oldest prediction
  always @(posedge clk) begin : check_words
    dac_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: sample_code %0d period_end %0d",
                 out_sample_code, out_period_end);
          fail_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (out_sample_code !== want.code) begin
            $error("sample_code mismatch: expected %0d, actual %0d",
                   want.code, out_sample_code);
            fail_cnt++;
          end
          if (out_period_end !== want.period_end) begin
            $error("period_end mismatch: expected %0d, actual %0d",
                   want.period_end, out_period_end);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Track register writes and watch for a hung handshake
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WAVE_KIND: wave_sel <= cfg_data[1:0];
        REG_AMPLITUDE: amp_level <= cfg_data;
        REG_DUTY:      duty_level <= cfg_data[6:0];
        default: ;
      endcase
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("waveform_sample_generator test failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [11:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued word has gone through and come back; look at the
  // falling edge so that the driver's and monitor's updates have landed
  task automatic settle();
    @(negedge clk);
    while (pending_restarts.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_words(input int count, input logic first_restart);
    for (int k = 0; k < count; k++) begin
      if (k == 0) begin
        pending_restarts.push_back(first_restart);
      end else begin
        pending_restarts.push_back($urandom_range(0, 49) == 0);
      end
    end
  endtask

  // Pick a register set, biased toward the extremes
  task automatic retune();
    logic [1:0] kind;
    logic [11:0] amp;
    logic [6:0] duty;
    int pick;
    pick = $urandom_range(0, 15);
    kind = (pick == 0) ? WAVE_UNKNOWN : 2'(pick % 3);
    pick = $urandom_range(0, 7);
    amp = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom_range(0, 4095));
    pick = $urandom_range(0, 11);
    case (pick)
      0:       duty = 7'd0;
      1:       duty = 7'd1;
      2:       duty = 7'd99;
      3:       duty = 7'd100;
      4:       duty = 7'd127;
      5:       duty = 7'($urandom_range(0, 127));
      default: duty = 7'($urandom_range(0, 100));
    endcase
    write_reg(REG_WAVE_KIND, {10'($urandom), kind});
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_DUTY, {5'($urandom), duty});
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_SPARE, 12'($urandom));
    end
  endtask

  initial begin
    int issued;
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, restart, flat and clamped shapes, unknown kind
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b0);
    pending_restarts.push_back(1'b1);
    pending_restarts.push_back(1'b0);
    settle();
    write_reg(REG_WAVE_KIND, {10'd0, WAVE_SQUARE});
    write_reg(REG_AMPLITUDE, 12'd4095);
    write_reg(REG_DUTY, 12'd0);
    queue_words(3, 1'b1);
    settle();
    write_reg(REG_DUTY, 12'd100);
    queue_words(3, 1'b0);
    settle();
    write_reg(REG_DUTY, 12'hFFF);
    queue_words(2, 1'b0);
    settle();
    write_reg(REG_WAVE_KIND, {10'd0, WAVE_TRIANGLE});
    write_reg(REG_DUTY, 12'd0);
    queue_words(3, 1'b1);
    settle();
    write_reg(REG_DUTY, 12'd100);
    write_reg(REG_SPARE, 12'hFFF);
    queue_words(2, 1'b1);
    settle();
    write_reg(REG_WAVE_KIND, 12'hFFF);
    queue_words(2, 1'b0);
    settle();
    write_reg(REG_WAVE_KIND, {10'h3FF, WAVE_SINE});
    write_reg(REG_AMPLITUDE, 12'd0);
    queue_words(2, 1'b0);
    settle();

    // Random runs of words under random settings and idling
    issued = 0;
    while (issued < 1200) begin
      retune();
      idle_on = ($urandom_range(0, 3) != 0);
      len = $urandom_range(30, 280);
      queue_words(len, $urandom_range(0, 1));
      issued += len;
      settle();
    end

    // Closing run at full rate
    retune();
    idle_on = 1'b0;
    queue_words(300, 1'b0);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d words never arrived", expected_words.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("waveform_sample_generator test passed");
    end else begin
      $display("waveform_sample_generator test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/wsg_pkg.sv
sv/wsg_ctrl.sv
sv/wsg_datapath.sv
sv/waveform_sample_generator.sv
sim/waveform_sample_generator_tb.sv
